FILE: src/nts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_pkg
// Types, constants and helpers shared by the nearest tensor search block.
// ----------------------------------------------------------------------------
package nts_pkg;

    localparam int unsigned NTS_MAX_POINTS     = 1024;
    localparam int unsigned NTS_COMPONENT_BITS = 32;
    localparam int unsigned NTS_NCOMP          = 6;
    localparam int unsigned NTS_NKIND          = 3;

    localparam int unsigned CFG_ADDR_W = 6;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [2:0] {
        REG_DIM_MODE   = 3'd0,
        REG_STRESS_TOL = 3'd1,
        REG_OTHER_TOL  = 3'd2,
        REG_STRESS_LIM = 3'd3,
        REG_OTHER_LIM  = 3'd4,
        REG_PRESS_WIN  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_QUERY  = 2'd2,
        OP_FQUERY = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_STRESS = 2'd0,
        KIND_STRAIN = 2'd1,
        KIND_FABRIC = 2'd2,
        KIND_BAD    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_MATCH    = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_REJECTED = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         entry;
        logic [1:0]         kind;
        logic signed [31:0] comp_xx;
        logic signed [31:0] comp_yy;
        logic signed [31:0] comp_zz;
        logic signed [31:0] comp_xy;
        logic signed [31:0] comp_yz;
        logic signed [31:0] comp_zx;
        logic signed [31:0] pressure;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  match_index;
        logic        within_tolerance;
        logic [63:0] squared_distance;
    } t_out_item;

    typedef struct packed {
        logic        dimension_mode;
        logic [62:0] stress_tolerance_sq;
        logic [62:0] other_tolerance_sq;
        logic [62:0] stress_limit_sq;
        logic [62:0] other_limit_sq;
        logic [30:0] pressure_window;
    } t_cfg;

    // Floor mean of the normal terms: (a+b)/2 in plane mode, (a+b+c)/3 in solid.
    // Division by three: offset to non-negative, split at bit 18 (2^18 = 1 mod 3),
    // then a reciprocal multiply on the small remainder sum.
    function automatic logic signed [33:0] nts_mean(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic signed [31:0] c,
        input logic               solid
    );
        logic signed [33:0] s;
        logic [33:0]        u;
        logic [15:0]        hi;
        logic [17:0]        lo;
        logic [18:0]        v;
        logic [32:0]        p1;
        logic [38:0]        p2;
        logic [33:0]        q3;
        s = 34'(a) + 34'(b) + (solid ? 34'(c) : 34'sd0);
        u = 34'(s) + 34'(64'd6442450944);
        hi = u[33:18];
        lo = u[17:0];
        v  = 19'(hi) + 19'(lo);
        p1 = 33'(hi) * 33'(17'd87381);
        p2 = 39'(v) * 39'(20'd699051);
        q3 = 34'(p1) + 34'(p2[38:21]);
        if (solid) begin
            return signed'(q3 - 34'(64'd2147483648));
        end
        return s >>> 1;
    endfunction

endpackage
`default_nettype wire

FILE: src/nts_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_in_if / nts_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface nts_in_if import nts_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface nts_out_if import nts_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/nts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module nts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/nts_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_cfg_regs
// APB register bank: mode, tolerances, limits and pressure window.
// ----------------------------------------------------------------------------
module nts_cfg_regs import nts_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[5:3]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dimension_mode      <= 1'b1;
            r_cfg.stress_tolerance_sq <= 63'd4294967296;
            r_cfg.other_tolerance_sq  <= 63'd43;
            r_cfg.stress_limit_sq     <= 63'd429496729600000000;
            r_cfg.other_limit_sq      <= 63'd4294967296;
            r_cfg.pressure_window     <= 31'd6554;
        end else if (w_wr) begin
            case (w_idx)
                REG_DIM_MODE:   r_cfg.dimension_mode      <= pwdata[0];
                REG_STRESS_TOL: r_cfg.stress_tolerance_sq <= pwdata[62:0];
                REG_OTHER_TOL:  r_cfg.other_tolerance_sq  <= pwdata[62:0];
                REG_STRESS_LIM: r_cfg.stress_limit_sq     <= pwdata[62:0];
                REG_OTHER_LIM:  r_cfg.other_limit_sq      <= pwdata[62:0];
                REG_PRESS_WIN:  r_cfg.pressure_window     <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DIM_MODE:   prdata = 64'(r_cfg.dimension_mode);
            REG_STRESS_TOL: prdata = 64'(r_cfg.stress_tolerance_sq);
            REG_OTHER_TOL:  prdata = 64'(r_cfg.other_tolerance_sq);
            REG_STRESS_LIM: prdata = 64'(r_cfg.stress_limit_sq);
            REG_OTHER_LIM:  prdata = 64'(r_cfg.other_limit_sq);
            REG_PRESS_WIN:  prdata = 64'(r_cfg.pressure_window);
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/nts_sq_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_sq_unit
// Shared weighted squarer: |diff|^2, doubled for shear terms, saturating.
// ----------------------------------------------------------------------------
module nts_sq_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [35:0] i_diff,
    input  wire logic               i_shear,
    output logic                    o_valid,
    output logic             [63:0] o_sq
);

    logic [35:0] w_mag;
    logic [63:0] w_prod;
    logic [63:0] n_sq;
    logic        r_valid;
    logic [63:0] r_sq;

    assign w_mag  = i_diff[35] ? 36'(-i_diff) : 36'(i_diff);
    assign w_prod = 64'(w_mag[31:0]) * 64'(w_mag[31:0]);

    always_comb begin
        if (|w_mag[35:32]) begin
            n_sq = '1;
        end else if (i_shear) begin
            n_sq = w_prod[63] ? '1 : {w_prod[62:0], 1'b0};
        end else begin
            n_sq = w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_sq <= n_sq;
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;

endmodule
`default_nettype wire

FILE: src/nearest_tensor_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_tensor_search_top
// Point store with load, clear and nearest tensor queries (plain and filtered).
// Each stored point is scanned with one registered store read and one squarer
// pass per component, C = 6 (solid) or 3 (plane); in a filtered query a point
// outside the pressure window is skipped before squaring. One item at a time;
// result is held in an output register. Synchronous active-low reset clears
// control and point count and restores config defaults.
// ----------------------------------------------------------------------------
module nearest_tensor_search_top import nts_pkg::*; #(
    parameter int unsigned MAX_POINTS     = NTS_MAX_POINTS,
    parameter int unsigned COMPONENT_BITS = NTS_COMPONENT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    nts_in_if.sink                     i_in,
    nts_out_if.source                  o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int unsigned IDXW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW     = $clog2(MAX_POINTS + 1);
    localparam int unsigned TDEPTH = MAX_POINTS * NTS_NKIND * NTS_NCOMP;
    localparam int unsigned TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int unsigned CB     = COMPONENT_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_QPREP = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_MEAN  = 8'b0001_0000,
        S_ACC   = 8'b0010_0000,
        S_CMP   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_cfg w_cfg;

    nts_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    t_state             r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic [1:0]         r_kind, n_kind;
    logic [9:0]         r_entry, n_entry;
    logic signed [34:0] r_q [NTS_NCOMP];
    logic signed [34:0] n_q [NTS_NCOMP];
    logic signed [34:0] r_d [NTS_NCOMP];
    logic signed [34:0] n_d [NTS_NCOMP];
    logic signed [31:0] r_qp, n_qp;
    logic [2:0]         r_cnt, n_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_count, n_count;
    logic [63:0]        r_acc, n_acc;
    logic [63:0]        r_best, n_best;
    logic [CW-1:0]      r_best_idx, n_best_idx;
    logic               r_found, n_found;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic                   w_solid;
    logic [2:0]             w_ncomp;
    logic [2:0]             w_nnorm;
    logic                   w_filt;
    logic [2:0]             w_cc;
    logic                   w_t_we;
    logic [TAW-1:0]         w_t_addr;
    logic [CB-1:0]          w_t_rdata;
    logic                   w_p_we;
    logic [31:0]            w_p_rdata;
    logic signed [CB-1:0]   w_t_sx;
    logic signed [33:0]     w_mq;
    logic signed [33:0]     w_md;
    logic signed [32:0]     w_pd;
    logic [32:0]            w_pd_mag;
    logic                   w_sq_valid;
    logic signed [35:0]     w_diff;
    logic                   w_sq_out_valid;
    logic [63:0]            w_sq;
    logic [64:0]            w_sum;
    logic [IDXW-1:0]        w_pidx;
    logic [IDXW-1:0]        w_tidx;
    logic signed [CB-1:0]   w_in_c [NTS_NCOMP];
    logic [63:0]            w_limit;
    logic [63:0]            w_tol;
    logic                   w_last;

    assign w_solid = w_cfg.dimension_mode;
    assign w_ncomp = w_solid ? 3'd6 : 3'd3;
    assign w_nnorm = w_solid ? 3'd3 : 3'd2;
    assign w_filt  = (t_opcode'(r_op) == OP_FQUERY);
    assign w_cc    = (r_cnt < 3'd6) ? r_cnt : 3'd0;
    assign w_limit = (t_kind'(r_kind) == KIND_STRESS) ? 64'(w_cfg.stress_limit_sq)
                                                      : 64'(w_cfg.other_limit_sq);
    assign w_tol   = (t_kind'(r_kind) == KIND_STRESS) ? 64'(w_cfg.stress_tolerance_sq)
                                                      : 64'(w_cfg.other_tolerance_sq);
    assign w_last  = ((r_idx + CW'(1)) == r_count);

    assign w_in_c[0] = i_in.payload.comp_xx[CB-1:0];
    assign w_in_c[1] = i_in.payload.comp_yy[CB-1:0];
    assign w_in_c[2] = i_in.payload.comp_zz[CB-1:0];
    assign w_in_c[3] = i_in.payload.comp_xy[CB-1:0];
    assign w_in_c[4] = i_in.payload.comp_yz[CB-1:0];
    assign w_in_c[5] = i_in.payload.comp_zx[CB-1:0];

    // store addressing: one row of six components per point and kind
    assign w_pidx = (r_state == S_LOAD) ? IDXW'(r_entry) : r_idx[IDXW-1:0];
    assign w_tidx = w_pidx;
    assign w_t_addr = TAW'(TAW'(w_tidx) * TAW'(NTS_NKIND * NTS_NCOMP))
                    + TAW'(TAW'(r_kind) * TAW'(NTS_NCOMP)) + TAW'(w_cc);
    assign w_t_we = (r_state == S_LOAD);
    assign w_p_we = (r_state == S_LOAD) && (r_cnt == 3'd0);

    nts_ram #(.WIDTH(CB), .DEPTH(TDEPTH)) u_tensor_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (w_t_addr),
        .i_wdata (r_q[w_cc][CB-1:0]),
        .i_raddr (w_t_addr),
        .o_rdata (w_t_rdata)
    );

    nts_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_press_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_pidx),
        .i_wdata (r_qp),
        .i_raddr (w_pidx),
        .o_rdata (w_p_rdata)
    );

    assign w_t_sx = w_t_rdata;
    assign w_mq = nts_mean(signed'(r_q[0][31:0]), signed'(r_q[1][31:0]),
                           signed'(r_q[2][31:0]), w_solid);
    assign w_md = nts_mean(signed'(r_d[0][31:0]), signed'(r_d[1][31:0]),
                           signed'(r_d[2][31:0]), w_solid);
    assign w_pd     = 33'(signed'(w_p_rdata)) - 33'(r_qp);
    assign w_pd_mag = w_pd[32] ? 33'(-w_pd) : 33'(w_pd);

    assign w_sq_valid = (r_state == S_ACC) && (r_cnt < w_ncomp);
    assign w_diff     = 36'(r_d[w_cc]) - 36'(r_q[w_cc]);

    nts_sq_unit u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .i_diff  (w_diff),
        .i_shear (w_cc >= w_nnorm),
        .o_valid (w_sq_out_valid),
        .o_sq    (w_sq)
    );

    assign w_sum = 65'(r_acc) + 65'(w_sq);

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_kind      = r_kind;
        n_entry     = r_entry;
        n_q         = r_q;
        n_d         = r_d;
        n_qp        = r_qp;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_count     = r_count;
        n_acc       = r_acc;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_found     = r_found;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.payload.opcode;
                    n_kind  = i_in.payload.kind;
                    n_entry = i_in.payload.entry;
                    n_qp    = i_in.payload.pressure;
                    for (int k = 0; k < NTS_NCOMP; k++) begin
                        n_q[k] = 35'(w_in_c[k]);
                    end
                    n_res = '0;
                    n_cnt = 3'd0;
                    if (t_opcode'(i_in.payload.opcode) == OP_CLEAR) begin
                        n_count      = '0;
                        n_res.status = ST_DONE;
                        n_state      = S_FIN;
                    end else if (t_kind'(i_in.payload.kind) == KIND_BAD) begin
                        n_res.status = ST_REJECTED;
                        n_state      = S_FIN;
                    end else if (t_opcode'(i_in.payload.opcode) == OP_LOAD) begin
                        if (32'(i_in.payload.entry) >= 32'(MAX_POINTS)) begin
                            n_res.status = ST_REJECTED;
                            n_state      = S_FIN;
                        end else begin
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_state = S_QPREP;
                    end
                end
            end
            S_LOAD: begin
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    if ((CW'(r_entry) + CW'(1)) > r_count) begin
                        n_count = CW'(r_entry) + CW'(1);
                    end
                    n_res.status = ST_DONE;
                    n_state      = S_FIN;
                end
            end
            S_QPREP: begin
                if (w_filt) begin
                    for (int k = 0; k < 3; k++) begin
                        if (3'(k) < w_nnorm) begin
                            n_q[k] = r_q[k] - 35'(w_mq);
                        end
                    end
                end
                n_best     = w_limit;
                n_best_idx = '0;
                n_found    = 1'b0;
                n_idx      = '0;
                n_cnt      = 3'd0;
                if (r_count == '0) begin
                    n_res.status = ST_NO_MATCH;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_cnt != 3'd0) begin
                    n_d[3'(r_cnt - 3'd1)] = 35'(w_t_sx);
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == w_ncomp) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                n_acc = '0;
                n_cnt = 3'd0;
                if (w_filt) begin
                    for (int k = 0; k < 3; k++) begin
                        if (3'(k) < w_nnorm) begin
                            n_d[k] = r_d[k] - 35'(w_md);
                        end
                    end
                end
                if (w_filt && (w_pd_mag > 33'(w_cfg.pressure_window))) begin
                    if (w_last) begin
                        n_state = S_FIN;
                        if (r_found) begin
                            n_res.status           = ST_MATCH;
                            n_res.match_index      = 10'(r_best_idx);
                            n_res.within_tolerance = (r_best <= w_tol);
                            n_res.squared_distance = r_best;
                        end else begin
                            n_res.status = ST_NO_MATCH;
                        end
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_FETCH;
                    end
                end else begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (w_sq_out_valid) begin
                    n_acc = w_sum[64] ? '1 : w_sum[63:0];
                end
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == w_ncomp) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_cnt = 3'd0;
                if (r_acc < r_best) begin
                    n_best     = r_acc;
                    n_best_idx = r_idx;
                    n_found    = 1'b1;
                end
                if (w_last) begin
                    n_state = S_FIN;
                    if (r_found || (r_acc < r_best)) begin
                        n_res.status           = ST_MATCH;
                        n_res.match_index      = 10'(n_best_idx);
                        n_res.within_tolerance = (n_best <= w_tol);
                        n_res.squared_distance = n_best;
                    end else begin
                        n_res.status = ST_NO_MATCH;
                    end
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_FETCH;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= 3'd0;
            r_idx       <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_found     <= n_found;
        end
        r_op       <= n_op;
        r_kind     <= n_kind;
        r_entry    <= n_entry;
        r_q        <= n_q;
        r_d        <= n_d;
        r_qp       <= n_qp;
        r_acc      <= n_acc;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule
`default_nettype wire
